/* src/bfid_pkg.sv */
// ----------------------------------------------------------------------------
// bfid_pkg
// Shared constants for the box filter image downscaler: register map, field
// widths and the configuration port geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package bfid_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 30;
    localparam int CFG_W    = 12;
    localparam int NCH_W    = 3;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_NUM_CHAN   = 3'd4;

endpackage

`default_nettype wire

/* src/box_filter_image_downscale.sv */
// ----------------------------------------------------------------------------
// box_filter_image_downscale
// Area-average downscaler: sums covered source samples per target column and
// channel in a line store, emits the truncated mean when a box completes.
// ----------------------------------------------------------------------------
// Item path: accept, then the line store update; when the item completes a box,
//   the count is taken with the update and an 8-step quotient runs before m_valid rises.
// s_ready is low while the line store update and, with a result, the serial divider
//   and output stage run; m_ready low while an earlier result is held holds the output stage.
// Reset: registers go to 1, then a band setup runs with s_ready low, rerun on
//   every register write; the line store is not cleared.
`default_nettype none

module box_filter_image_downscale #(
    parameter int MAX_DIM      = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [bfid_pkg::APB_AW-1:0]   paddr,
    input  wire [bfid_pkg::APB_DW-1:0]   pwdata,
    output logic [bfid_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // source samples
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [bfid_pkg::SAMPLE_W-1:0] s_sample,
    input  wire                          s_frame_start,
    // target samples
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [bfid_pkg::SAMPLE_W-1:0] m_avg_value,
    output logic                         m_last_of_frame
);
    import bfid_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int DEPTH  = MAX_DIM * MAX_CHANNELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = 2 * DIM_W;
    localparam int DV_W   = (CNT_W + SAMPLE_W > SUM_W) ? CNT_W + SAMPLE_W : SUM_W;
    localparam int CC_W   = $clog2(DIM_W + 2);

    localparam logic [2:0] ST_CALC = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // configuration registers
    logic [CFG_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [NCH_W-1:0] num_chan_reg;

    logic [2:0] state_reg;

    // band step: S = q*D + r per axis
    logic [DIM_W-1:0] qw_reg, rw_reg, qh_reg, rh_reg;
    logic [CC_W-1:0]  ccnt_reg;

    // stream counters
    logic [DIM_W-1:0] src_col_reg, src_row_reg, dst_col_reg;
    logic [CH_W-1:0]  chan_reg;
    logic [DIM_W-1:0] col_start_reg, col_bound_reg, col_rem_reg;
    logic [DIM_W-1:0] row_start_reg, row_bound_reg, row_rem_reg;

    // item path
    logic [SAMPLE_W-1:0] smp_reg;
    logic [AW-1:0]       addr_reg;
    logic [SUM_W-1:0]    rdata_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [DV_W-1:0]     drem_reg;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [2:0]          dstep_reg;
    logic                last_reg;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_avg_reg;
    logic                m_last_reg;

    // line store
    logic [SUM_W-1:0] sum_mem [DEPTH];

    // effective sizes after clamping
    logic [DIM_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
    logic [CH_W-1:0]  nc_eff;

    always_comb begin
        logic [31:0] v;
        v = {20'd0, src_width_reg};
        sw_eff = DIM_W'((v == 0) ? 32'd1 : (v > MAX_DIM) ? 32'(MAX_DIM) : v);
        v = {20'd0, src_height_reg};
        sh_eff = DIM_W'((v == 0) ? 32'd1 : (v > MAX_DIM) ? 32'(MAX_DIM) : v);
        v = {20'd0, dst_width_reg};
        dw_eff = DIM_W'((v == 0) ? 32'd1 : (v > 32'(sw_eff)) ? 32'(sw_eff) : v);
        v = {20'd0, dst_height_reg};
        dh_eff = DIM_W'((v == 0) ? 32'd1 : (v > 32'(sh_eff)) ? 32'(sh_eff) : v);
        v = {29'd0, num_chan_reg};
        nc_eff = CH_W'((v == 0) ? 32'd1 : (v > MAX_CHANNELS) ? 32'(MAX_CHANNELS) : v);
    end

    // setup divider step, both axes in parallel
    logic [DIM_W:0]   cw_trial, ch_trial;
    logic             cw_bit, ch_bit;
    logic [DIM_W-1:0] cw_rem_n, ch_rem_n;

    always_comb begin
        cw_trial = {rw_reg, qw_reg[DIM_W-1]};
        cw_bit   = cw_trial >= {1'b0, dw_eff};
        cw_rem_n = cw_bit ? DIM_W'(cw_trial - {1'b0, dw_eff}) : DIM_W'(cw_trial);
        ch_trial = {rh_reg, qh_reg[DIM_W-1]};
        ch_bit   = ch_trial >= {1'b0, dh_eff};
        ch_rem_n = ch_bit ? DIM_W'(ch_trial - {1'b0, dh_eff}) : DIM_W'(ch_trial);
    end

    // next band bounds
    logic [DIM_W:0]   col_rsum, row_rsum;
    logic             col_cy, row_cy;
    logic [DIM_W-1:0] col_bound_n, col_rem_n, row_bound_n, row_rem_n;

    always_comb begin
        col_rsum    = {1'b0, col_rem_reg} + {1'b0, rw_reg};
        col_cy      = col_rsum >= {1'b0, dw_eff};
        col_rem_n   = col_cy ? DIM_W'(col_rsum - {1'b0, dw_eff}) : DIM_W'(col_rsum);
        col_bound_n = col_bound_reg + qw_reg + DIM_W'(col_cy);
        row_rsum    = {1'b0, row_rem_reg} + {1'b0, rh_reg};
        row_cy      = row_rsum >= {1'b0, dh_eff};
        row_rem_n   = row_cy ? DIM_W'(row_rsum - {1'b0, dh_eff}) : DIM_W'(row_rsum);
        row_bound_n = row_bound_reg + qh_reg + DIM_W'(row_cy);
    end

    // accumulate
    logic             first_smp;
    logic [SUM_W-1:0] acc;
    logic             box_done;
    logic             frame_last;
    logic [CH_W-1:0]  chan_n;
    logic [DIM_W-1:0] scol_n, srow_n;

    always_comb begin
        first_smp  = (src_row_reg == row_start_reg) && (src_col_reg == col_start_reg);
        acc        = first_smp ? SUM_W'(smp_reg) : rdata_reg + SUM_W'(smp_reg);
        chan_n     = chan_reg + 1'b1;
        scol_n     = src_col_reg + 1'b1;
        srow_n     = src_row_reg + 1'b1;
        box_done   = (srow_n == row_bound_reg) && (scol_n == col_bound_reg);
        frame_last = (srow_n == sh_eff) && (scol_n == sw_eff) && (chan_n == nc_eff);
    end

    // quotient step
    logic [DV_W-1:0] dtrial;
    logic            dbit;

    always_comb begin
        dtrial = DV_W'(count_reg) << dstep_reg;
        dbit   = drem_reg >= dtrial;
    end

    logic cfg_wr;
    logic s_acc;
    logic out_load;
    logic [2:0] cfg_idx;

    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[4:2];
    assign s_acc    = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign pready   = 1'b1;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(src_width_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(src_height_reg);
            REG_DST_WIDTH:  prdata = APB_DW'(dst_width_reg);
            REG_DST_HEIGHT: prdata = APB_DW'(dst_height_reg);
            REG_NUM_CHAN:   prdata = APB_DW'(num_chan_reg);
            default:        prdata = '0;
        endcase
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            sum_mem[addr_reg] <= acc;
        end
        rdata_reg <= sum_mem[s_frame_start ? AW'(0)
                             : AW'(dst_col_reg * MAX_CHANNELS) + AW'(chan_reg)];
    end

    // control and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= CFG_W'(1);
            src_height_reg <= CFG_W'(1);
            dst_width_reg  <= CFG_W'(1);
            dst_height_reg <= CFG_W'(1);
            num_chan_reg   <= NCH_W'(1);
            state_reg      <= ST_CALC;
            ccnt_reg       <= '0;
            qw_reg         <= '0;
            rw_reg         <= '0;
            qh_reg         <= '0;
            rh_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // result register
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_avg_reg   <= quo_reg;
                m_last_reg  <= last_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // register write: store value
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_SRC_WIDTH:  src_width_reg  <= pwdata[CFG_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= pwdata[CFG_W-1:0];
                    REG_DST_WIDTH:  dst_width_reg  <= pwdata[CFG_W-1:0];
                    REG_DST_HEIGHT: dst_height_reg <= pwdata[CFG_W-1:0];
                    REG_NUM_CHAN:   num_chan_reg   <= pwdata[NCH_W-1:0];
                    default: ;
                endcase
            end

            if (cfg_wr && cfg_idx <= REG_NUM_CHAN) begin
                // rerun band setup
                state_reg <= ST_CALC;
                ccnt_reg  <= '0;
            end else begin
                unique case (state_reg)
                    ST_CALC: begin
                        ccnt_reg <= ccnt_reg + 1'b1;
                        if (ccnt_reg == '0) begin
                            // load the source sizes as dividends
                            qw_reg <= sw_eff;
                            rw_reg <= '0;
                            qh_reg <= sh_eff;
                            rh_reg <= '0;
                        end else if (ccnt_reg == CC_W'(DIM_W + 1)) begin
                            // quotients settled: restart counters
                            src_col_reg   <= '0;
                            src_row_reg   <= '0;
                            chan_reg      <= '0;
                            dst_col_reg   <= '0;
                            col_start_reg <= '0;
                            col_bound_reg <= qw_reg;
                            col_rem_reg   <= rw_reg;
                            row_start_reg <= '0;
                            row_bound_reg <= qh_reg;
                            row_rem_reg   <= rh_reg;
                            state_reg     <= ST_IDLE;
                        end else begin
                            qw_reg <= {qw_reg[DIM_W-2:0], cw_bit};
                            rw_reg <= cw_rem_n;
                            qh_reg <= {qh_reg[DIM_W-2:0], ch_bit};
                            rh_reg <= ch_rem_n;
                        end
                    end
                    ST_IDLE: begin
                        if (s_acc) begin
                            smp_reg  <= s_sample;
                            addr_reg <= s_frame_start ? AW'(0)
                                        : AW'(dst_col_reg * MAX_CHANNELS) + AW'(chan_reg);
                            if (s_frame_start) begin
                                src_col_reg   <= '0;
                                src_row_reg   <= '0;
                                chan_reg      <= '0;
                                dst_col_reg   <= '0;
                                col_start_reg <= '0;
                                col_bound_reg <= qw_reg;
                                col_rem_reg   <= rw_reg;
                                row_start_reg <= '0;
                                row_bound_reg <= qh_reg;
                                row_rem_reg   <= rh_reg;
                            end
                            state_reg <= ST_UPD;
                        end
                    end
                    ST_UPD: begin
                        count_reg <= CNT_W'((col_bound_reg - col_start_reg) *
                                            (row_bound_reg - row_start_reg));
                        drem_reg  <= DV_W'(acc);
                        quo_reg   <= '0;
                        dstep_reg <= 3'd7;
                        last_reg  <= frame_last;
                        state_reg <= box_done ? ST_DIV : ST_IDLE;
                        // advance counters
                        if (chan_n >= nc_eff) begin
                            chan_reg <= '0;
                            if (scol_n >= sw_eff) begin
                                src_col_reg   <= '0;
                                dst_col_reg   <= '0;
                                col_start_reg <= '0;
                                col_bound_reg <= qw_reg;
                                col_rem_reg   <= rw_reg;
                                if (srow_n >= sh_eff) begin
                                    src_row_reg   <= '0;
                                    row_start_reg <= '0;
                                    row_bound_reg <= qh_reg;
                                    row_rem_reg   <= rh_reg;
                                end else begin
                                    src_row_reg <= srow_n;
                                    if (srow_n >= row_bound_reg) begin
                                        row_start_reg <= row_bound_reg;
                                        row_bound_reg <= row_bound_n;
                                        row_rem_reg   <= row_rem_n;
                                    end
                                end
                            end else begin
                                src_col_reg <= scol_n;
                                if (scol_n >= col_bound_reg) begin
                                    dst_col_reg   <= dst_col_reg + 1'b1;
                                    col_start_reg <= col_bound_reg;
                                    col_bound_reg <= col_bound_n;
                                    col_rem_reg   <= col_rem_n;
                                end
                            end
                        end else begin
                            chan_reg <= chan_n;
                        end
                    end
                    ST_DIV: begin
                        // one quotient bit per cycle, mean fits 8 bits
                        if (dbit) begin
                            drem_reg <= drem_reg - dtrial;
                        end
                        quo_reg   <= {quo_reg[SAMPLE_W-2:0], dbit};
                        dstep_reg <= dstep_reg - 1'b1;
                        if (dstep_reg == 3'd0) begin
                            state_reg <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        if (out_load) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_CALC;
                    end
                endcase
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_avg_value     = m_avg_reg;
    assign m_last_of_frame = m_last_reg;

endmodule

`default_nettype wire
